### rtl/assert_macros.svh
// Assertion macros used by the RTL top level of the quantizer.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bgq_pkg.sv
// Shared constants, types and codes of the bar grid note quantizer.
// No dependencies; used by every module of the block but bgq_ram.
package bgq_pkg;

  localparam int MAX_BARS   = 1024;
  localparam int MAX_STEPS  = 999;
  localparam int STEP_RESET = 24;

  localparam int LEN_W  = 16;
  localparam int TICK_W = 24;
  localparam int BIDX_W = 10;
  localparam int CFG_W  = 2;
  localparam int DATA_W = 16;

  localparam int BAR_W   = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int SUM_W   = LEN_W + BAR_W;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int DIV_W   = TICK_W + 1;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int PROD_W  = STEP_W + LEN_W;
  localparam int SNAP_W  = ((SUM_W > PROD_W) ? SUM_W : PROD_W) + 1;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUANT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_STEP  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_FIRST = 2'd1;
  localparam logic [CFG_W-1:0] CFG_LAST  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_STEPS,
    ST_STEPS_WAIT,
    ST_IDX,
    ST_IDX_WAIT,
    ST_MUL,
    ST_ADD
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0] bar_start;
    logic [SUM_W-1:0] seg_start;
    logic [SUM_W-1:0] seg_end;
    logic [LEN_W-1:0] len;
  } scan_res_t;

endpackage

### rtl/bar_grid_note_quantizer_unit.sv
// Top level of the bar grid note quantizer: control sequencer, config
// registers and output register. Depends on bgq_pkg, bgq_ram, bgq_scan,
// bgq_div and assert_macros.svh.
//
// Usage:
//   Items enter on start while busy is low. kind 0 writes bar_ticks into the
//   bar table at bar_index in the same cycle; busy stays low and no result
//   follows. kind 1 quantizes note_tick; busy rises and one result beat
//   comes out on snapped_tick/matched, marked by done for one cycle.
//   A quantize reads the bar table once per bar over all 1024 bars through
//   the single RAM read port, then runs up to two divisions in the shared
//   divider, a multiply and an add before its result beat comes out.
//   The next item may be offered in the cycle done is high.
//   Config writes (cfg_write, cfg_index, cfg_data) land at the next edge;
//   issue them only while no quantize is in flight.
//   After reset the block zeroes the bar table, one entry a cycle, with busy
//   high. The receiver cannot stall: a result beat is valid only in the
//   cycle done is high.
`include "assert_macros.svh"

module bar_grid_note_quantizer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        kind,
  input  logic [bgq_pkg::BIDX_W-1:0]  bar_index,
  input  logic [bgq_pkg::LEN_W-1:0]   bar_ticks,
  input  logic [bgq_pkg::TICK_W-1:0]  note_tick,
  input  logic                        cfg_write,
  input  logic [bgq_pkg::CFG_W-1:0]   cfg_index,
  input  logic [bgq_pkg::DATA_W-1:0]  cfg_data,
  output logic                        done,
  output logic [bgq_pkg::TICK_W-1:0]  snapped_tick,
  output logic                        matched
);

  bgq_pkg::state_t state;
  bgq_pkg::state_t state_next;

  logic [bgq_pkg::LEN_W-1:0]   step_length;
  logic [bgq_pkg::BIDX_W-1:0]  first_bar;
  logic [bgq_pkg::BIDX_W-1:0]  last_bar;

  logic [bgq_pkg::BAR_W-1:0]   clr_addr;
  logic [bgq_pkg::TICK_W-1:0]  tick;
  logic [bgq_pkg::TICK_W-1:0]  off;
  logic [bgq_pkg::SUM_W-1:0]   bar_start;
  logic [bgq_pkg::SUM_W-1:0]   seg_start;
  logic [bgq_pkg::SUM_W-1:0]   seg_end;
  logic [bgq_pkg::LEN_W-1:0]   blen;
  logic [bgq_pkg::STEP_W-1:0]  steps;
  logic [bgq_pkg::STEP_W-1:0]  idx;
  logic [bgq_pkg::PROD_W-1:0]  prod;

  logic                        mem_we;
  logic [bgq_pkg::BAR_W-1:0]   mem_waddr;
  logic [bgq_pkg::LEN_W-1:0]   mem_wdata;
  logic                        mem_re;
  logic [bgq_pkg::BAR_W-1:0]   mem_raddr;
  logic [bgq_pkg::LEN_W-1:0]   mem_rdata;

  logic                        scan_start;
  logic                        scan_done;
  bgq_pkg::scan_res_t          scan_res;

  logic                        div_start;
  logic [bgq_pkg::DIV_W-1:0]   div_dividend;
  logic                        div_done;
  logic [bgq_pkg::DIV_W-1:0]   div_quotient;

  logic [bgq_pkg::LEN_W-1:0]   half;
  logic                        in_range;
  logic                        near_start;
  logic                        over;
  logic [bgq_pkg::DIV_W-1:0]   num;
  logic [bgq_pkg::SNAP_W-1:0]  snap_sum;
  logic                        res_fire;
  logic                        res_hit;
  logic [bgq_pkg::TICK_W-1:0]  res_tick;

  bgq_ram #(
    .WIDTH (bgq_pkg::LEN_W),
    .DEPTH (bgq_pkg::MAX_BARS)
  ) u_bar_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bgq_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .tick      (tick),
    .first_bar (first_bar),
    .last_bar  (last_bar),
    .rd_en     (mem_re),
    .rd_addr   (mem_raddr),
    .rd_data   (mem_rdata),
    .done      (scan_done),
    .res       (scan_res)
  );

  bgq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (step_length),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign busy = (state != bgq_pkg::ST_IDLE);

  always_comb begin
    half       = step_length >> 1;
    in_range   = 32'(bar_index) < bgq_pkg::MAX_BARS;
    near_start = bgq_pkg::DIV_W'(off) <= bgq_pkg::DIV_W'(half);
    over       = div_quotient > bgq_pkg::DIV_W'(steps);
    num        = bgq_pkg::DIV_W'(off) - bgq_pkg::DIV_W'(half)
               + bgq_pkg::DIV_W'(step_length) - bgq_pkg::DIV_W'(1);
    snap_sum   = bgq_pkg::SNAP_W'(prod) + bgq_pkg::SNAP_W'(bar_start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgq_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    mem_we       = 1'b0;
    mem_waddr    = clr_addr;
    mem_wdata    = '0;
    scan_start   = 1'b0;
    div_start    = 1'b0;
    div_dividend = bgq_pkg::DIV_W'(blen);
    res_fire     = 1'b0;
    res_hit      = 1'b0;
    res_tick     = tick;
    unique case (state)
      bgq_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == bgq_pkg::BAR_W'(bgq_pkg::MAX_BARS - 1)) begin
          state_next = bgq_pkg::ST_IDLE;
        end
      end
      bgq_pkg::ST_IDLE: begin
        if (start) begin
          if (kind == bgq_pkg::KIND_LOAD) begin
            mem_we    = in_range;
            mem_waddr = bgq_pkg::BAR_W'(bar_index);
            mem_wdata = bar_ticks;
          end else begin
            scan_start = 1'b1;
            state_next = bgq_pkg::ST_SCAN;
          end
        end
      end
      bgq_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_next = bgq_pkg::ST_STEPS;
        end
      end
      bgq_pkg::ST_STEPS: begin
        if (step_length == '0) begin
          state_next = bgq_pkg::ST_IDX;
        end else begin
          div_start  = 1'b1;
          state_next = bgq_pkg::ST_STEPS_WAIT;
        end
      end
      bgq_pkg::ST_STEPS_WAIT: begin
        if (div_done) begin
          state_next = bgq_pkg::ST_IDX;
        end
      end
      bgq_pkg::ST_IDX: begin
        if (near_start) begin
          state_next = bgq_pkg::ST_MUL;
        end else if (step_length == '0) begin
          // zero step: only offset zero can match
          res_fire   = 1'b1;
          state_next = bgq_pkg::ST_IDLE;
        end else begin
          div_start    = 1'b1;
          div_dividend = num;
          state_next   = bgq_pkg::ST_IDX_WAIT;
        end
      end
      bgq_pkg::ST_IDX_WAIT: begin
        if (div_done) begin
          if (over) begin
            res_fire   = 1'b1;
            state_next = bgq_pkg::ST_IDLE;
          end else begin
            state_next = bgq_pkg::ST_MUL;
          end
        end
      end
      bgq_pkg::ST_MUL: begin
        state_next = bgq_pkg::ST_ADD;
      end
      bgq_pkg::ST_ADD: begin
        res_fire = 1'b1;
        res_hit  = 1'b1;
        // wrap on the full sum, then drop to tick width
        if (snap_sum >= bgq_pkg::SNAP_W'(seg_end)) begin
          res_tick = bgq_pkg::TICK_W'(seg_start);
        end else begin
          res_tick = bgq_pkg::TICK_W'(snap_sum);
        end
        state_next = bgq_pkg::ST_IDLE;
      end
      default: begin
        state_next = bgq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == bgq_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      tick <= note_tick;
    end
    if (state == bgq_pkg::ST_SCAN && scan_done) begin
      bar_start <= scan_res.bar_start;
      seg_start <= scan_res.seg_start;
      seg_end   <= scan_res.seg_end;
      blen      <= scan_res.len;
      off       <= tick - bgq_pkg::TICK_W'(scan_res.bar_start);
    end
    if (state == bgq_pkg::ST_STEPS && step_length == '0) begin
      steps <= '0;
    end
    if (state == bgq_pkg::ST_STEPS_WAIT && div_done) begin
      // saturate the whole-step count
      if (div_quotient > bgq_pkg::DIV_W'(bgq_pkg::MAX_STEPS)) begin
        steps <= bgq_pkg::STEP_W'(bgq_pkg::MAX_STEPS);
      end else begin
        steps <= bgq_pkg::STEP_W'(div_quotient);
      end
    end
    if (state == bgq_pkg::ST_IDX && near_start) begin
      idx <= '0;
    end
    if (state == bgq_pkg::ST_IDX_WAIT && div_done) begin
      idx <= bgq_pkg::STEP_W'(div_quotient);
    end
    if (state == bgq_pkg::ST_MUL) begin
      prod <= bgq_pkg::PROD_W'(idx) * bgq_pkg::PROD_W'(step_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= bgq_pkg::LEN_W'(bgq_pkg::STEP_RESET);
      first_bar   <= '0;
      last_bar    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bgq_pkg::CFG_STEP:  step_length <= cfg_data[bgq_pkg::LEN_W-1:0];
        bgq_pkg::CFG_FIRST: first_bar   <= cfg_data[bgq_pkg::BIDX_W-1:0];
        bgq_pkg::CFG_LAST:  last_bar    <= cfg_data[bgq_pkg::BIDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_fire;
    end
    if (res_fire) begin
      snapped_tick <= res_tick;
      matched      <= res_hit;
    end
  end

  `ASSERT_IMPLIES(a_done_source, clk, rst, done,
    $past(state) == bgq_pkg::ST_ADD || $past(state) == bgq_pkg::ST_IDX || $past(state) == bgq_pkg::ST_IDX_WAIT,
    "result beat without a finishing quantize step")
  `ASSERT_NEXT(a_single_beat, clk, rst, done, !done, "two result beats in a row")
  `ASSERT_NEXT(a_load_silent, clk, rst, start && !busy && kind == bgq_pkg::KIND_LOAD, !done,
    "load item produced a result beat")
  `ASSERT_IMPLIES(a_div_nonzero, clk, rst, div_start, step_length != '0,
    "divider started with zero step length")

endmodule

### rtl/bgq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bgq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bgq_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bgq_pkg for widths.
module bgq_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bgq_pkg::DIV_W-1:0]  dividend,
  input  logic [bgq_pkg::LEN_W-1:0]  divisor,
  output logic                       done,
  output logic [bgq_pkg::DIV_W-1:0]  quotient
);

  logic                        running;
  logic [bgq_pkg::DCNT_W-1:0]  cnt;
  logic [bgq_pkg::LEN_W-1:0]   rem;
  logic [bgq_pkg::LEN_W-1:0]   dsr;
  logic [bgq_pkg::DIV_W-1:0]   quo;
  logic [bgq_pkg::LEN_W:0]     trial;
  logic                        ge;
  logic [bgq_pkg::LEN_W:0]     diff;

  always_comb begin
    trial = {rem, quo[bgq_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= dividend;
        dsr     <= divisor;
      end else if (running) begin
        // shift the next dividend bit in, keep the quotient bit
        rem <= ge ? diff[bgq_pkg::LEN_W-1:0] : trial[bgq_pkg::LEN_W-1:0];
        quo <= {quo[bgq_pkg::DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == bgq_pkg::DCNT_W'(bgq_pkg::DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/bgq_scan.sv
// Bar table walker: reads every bar length once, forms the segment sums and
// finds the bar that holds the tick. Depends on bgq_pkg.
module bgq_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bgq_pkg::TICK_W-1:0]  tick,
  input  logic [bgq_pkg::BIDX_W-1:0]  first_bar,
  input  logic [bgq_pkg::BIDX_W-1:0]  last_bar,
  output logic                        rd_en,
  output logic [bgq_pkg::BAR_W-1:0]   rd_addr,
  input  logic [bgq_pkg::LEN_W-1:0]   rd_data,
  output logic                        done,
  output bgq_pkg::scan_res_t          res
);

  logic                       issuing;
  logic [bgq_pkg::BAR_W-1:0]  cnt;
  logic                       d_vld;
  logic [bgq_pkg::BAR_W-1:0]  d_idx;
  logic [bgq_pkg::SUM_W-1:0]  acc;
  logic [bgq_pkg::SUM_W-1:0]  acc_next;
  logic [bgq_pkg::SUM_W-1:0]  seg_start;
  logic [bgq_pkg::SUM_W-1:0]  seg_end;
  logic [bgq_pkg::SUM_W-1:0]  bar_start;
  logic [bgq_pkg::LEN_W-1:0]  blen;
  logic [bgq_pkg::LEN_W-1:0]  len0;
  logic                       found;
  logic                       in_seg;
  logic                       before_first;

  assign rd_en   = issuing;
  assign rd_addr = cnt;

  always_comb begin
    acc_next     = acc + bgq_pkg::SUM_W'(rd_data);
    in_seg       = 32'(d_idx) <= 32'(last_bar);
    before_first = 32'(d_idx) < 32'(first_bar);
  end

  // a tick in no bar falls back to bar 0 at start 0
  always_comb begin
    res.bar_start = found ? bar_start : '0;
    res.seg_start = seg_start;
    res.seg_end   = seg_end;
    res.len       = found ? blen : len0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      d_vld   <= 1'b0;
      done    <= 1'b0;
    end else begin
      done  <= 1'b0;
      d_vld <= issuing;
      d_idx <= cnt;
      if (start) begin
        issuing   <= 1'b1;
        cnt       <= '0;
        acc       <= '0;
        seg_start <= '0;
        seg_end   <= '0;
        found     <= 1'b0;
      end else if (issuing) begin
        cnt <= cnt + 1'b1;
        if (cnt == bgq_pkg::BAR_W'(bgq_pkg::MAX_BARS - 1)) begin
          issuing <= 1'b0;
        end
      end
      if (d_vld) begin
        acc <= acc_next;
        if (in_seg) begin
          seg_end <= seg_end + bgq_pkg::SUM_W'(rd_data);
          if (before_first) begin
            seg_start <= seg_start + bgq_pkg::SUM_W'(rd_data);
          end
        end
        if (d_idx == '0) begin
          len0 <= rd_data;
        end
        if (!found && (32'(tick) < 32'(acc_next))) begin
          found     <= 1'b1;
          bar_start <= acc;
          blen      <= rd_data;
        end
        if (d_idx == bgq_pkg::BAR_W'(bgq_pkg::MAX_BARS - 1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule
